>>> sv/satb_pkg.sv
// Shared types, constants and the divider step function for the saturation enhancer.
package satb_pkg;

    localparam int NUM_CH = 3;
    localparam int CH_W = 8;
    localparam int SUM_W = 10;
    localparam int NUM_W = 16;
    localparam int DEN_W = 9;
    localparam int GAIN_W = 12;
    localparam int PROD_W = CH_W + GAIN_W;
    localparam int GAIN_SHIFT = 8;
    localparam int MEAN_PROD_W = 2 * SUM_W;
    localparam int MEAN_SHIFT = 11;
    localparam int DIV_BITS = 8;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES = DIV_BITS / DIV_BITS_PER_STAGE;

    localparam logic [CH_W-1:0] CHAN_MAX = 8'd255;
    localparam logic [DEN_W-1:0] DEN_BASE = 9'd256;
    localparam logic [SUM_W-1:0] MEAN_RECIP = 10'd683;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd256;

    typedef logic [CH_W-1:0] satb_chan_t;

    typedef struct packed {
        logic [CH_W-1:0]  c;
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic [CH_W-1:0]  q;
    } satb_lane_t;

    typedef satb_lane_t [NUM_CH-1:0] satb_px_t;
    typedef satb_chan_t [NUM_CH-1:0] satb_rgb_t;

    function automatic satb_lane_t div_step(input satb_lane_t l, input logic [2:0] sh);
        logic [NUM_W:0] d;
        satb_lane_t     r;
        d = {{(NUM_W + 1 - DEN_W){1'b0}}, l.den} << sh;
        r = l;
        if ({1'b0, l.rem} >= d) begin
            r.rem = l.rem - d[NUM_W-1:0];
            r.q = {l.q[CH_W-2:0], 1'b1};
        end else begin
            r.q = {l.q[CH_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

>>> sv/rgb_color_saturation_enhance.sv
// Top level of the RGB saturation enhancer: gain register and the three pipeline sections.
// Throughput is one pixel per cycle while m_ready is high: 3 front stages, 4 divider stages, 2 back stages.
// Each stage holds its transaction until the next one frees, so bubbles are filled.
// Reset is synchronous and active low; it empties the pipeline and sets the gain to 1.0.
module rgb_color_saturation_enhance (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [satb_pkg::GAIN_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [satb_pkg::CH_W-1:0]   s_red_in,
    input  logic [satb_pkg::CH_W-1:0]   s_green_in,
    input  logic [satb_pkg::CH_W-1:0]   s_blue_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [satb_pkg::CH_W-1:0]   m_red_out,
    output logic [satb_pkg::CH_W-1:0]   m_green_out,
    output logic [satb_pkg::CH_W-1:0]   m_blue_out
);

    logic [satb_pkg::GAIN_W-1:0] gain_reg;
    satb_pkg::satb_rgb_t         in_rgb, out_rgb;
    satb_pkg::satb_px_t          front_px, div_px;
    logic                        front_valid, front_ready;
    logic                        div_valid, div_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= satb_pkg::GAIN_RESET;
        end else if (cfg_wr_en) begin
            gain_reg <= cfg_wr_data;
        end
    end

    assign in_rgb[0] = s_red_in;
    assign in_rgb[1] = s_green_in;
    assign in_rgb[2] = s_blue_in;

    satb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_rgb    (in_rgb),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_px    (front_px)
    );

    satb_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_px     (front_px),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_px    (div_px)
    );

    satb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gain      (gain_reg),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_px     (div_px),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_rgb   (out_rgb)
    );

    assign m_red_out = out_rgb[0];
    assign m_green_out = out_rgb[1];
    assign m_blue_out = out_rgb[2];

endmodule

>>> sv/satb_front.sv
// Front pipeline: channel sum, mean, and per-channel numerator and denominator.
module satb_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  satb_pkg::satb_rgb_t in_rgb,
    output logic                out_valid,
    input  logic                out_ready,
    output satb_pkg::satb_px_t  out_px
);

    logic                                   valid1_reg, valid2_reg, valid3_reg;
    logic                                   rdy1, rdy2, rdy3;
    satb_pkg::satb_rgb_t                    rgb1_reg, rgb2_reg;
    logic [satb_pkg::SUM_W-1:0]             sum1_reg, sum1_next;
    logic [satb_pkg::CH_W-1:0]              mean2_reg, mean2_next;
    logic [satb_pkg::MEAN_PROD_W-1:0]       mean_prod;
    satb_pkg::satb_px_t                     px3_reg, px3_next;

    assign rdy3 = !valid3_reg || out_ready;
    assign rdy2 = !valid2_reg || rdy3;
    assign rdy1 = !valid1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = valid3_reg;
    assign out_px = px3_reg;

    assign sum1_next = {2'b00, in_rgb[0]} + {2'b00, in_rgb[1]} + {2'b00, in_rgb[2]};
    assign mean_prod =
        {{(satb_pkg::MEAN_PROD_W - satb_pkg::SUM_W){1'b0}}, sum1_reg}
        * {{(satb_pkg::MEAN_PROD_W - satb_pkg::SUM_W){1'b0}}, satb_pkg::MEAN_RECIP};
    assign mean2_next = mean_prod[satb_pkg::MEAN_SHIFT +: satb_pkg::CH_W];

    always_comb begin
        logic                        gt;
        logic [satb_pkg::CH_W-1:0]   c;
        logic [satb_pkg::CH_W-1:0]   diff;
        logic [satb_pkg::CH_W-1:0]   fac;
        for (int i = 0; i < satb_pkg::NUM_CH; i++) begin
            c = rgb2_reg[i];
            gt = c > mean2_reg;
            diff = gt ? c - mean2_reg : mean2_reg - c;
            fac = gt ? satb_pkg::CHAN_MAX - c : satb_pkg::CHAN_MAX - mean2_reg;
            px3_next[i].c = c;
            px3_next[i].rem = {{(satb_pkg::NUM_W - satb_pkg::CH_W){1'b0}}, diff}
                            * {{(satb_pkg::NUM_W - satb_pkg::CH_W){1'b0}}, fac};
            px3_next[i].den = gt ? satb_pkg::DEN_BASE - {1'b0, mean2_reg}
                                 : satb_pkg::DEN_BASE - {1'b0, c};
            px3_next[i].neg = !gt;
            px3_next[i].q = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                valid1_reg <= in_valid;
            end
            if (rdy2) begin
                valid2_reg <= valid1_reg;
            end
            if (rdy3) begin
                valid3_reg <= valid2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            rgb1_reg <= in_rgb;
            sum1_reg <= sum1_next;
        end
        if (rdy2 && valid1_reg) begin
            rgb2_reg <= rgb1_reg;
            mean2_reg <= mean2_next;
        end
        if (rdy3 && valid2_reg) begin
            px3_reg <= px3_next;
        end
    end

endmodule

>>> sv/satb_div.sv
// Pipelined restoring divider, two quotient bits per stage for all three channels.
module satb_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  satb_pkg::satb_px_t in_px,
    output logic               out_valid,
    input  logic               out_ready,
    output satb_pkg::satb_px_t out_px
);

    logic [satb_pkg::DIV_STAGES-1:0] valid_reg;
    logic [satb_pkg::DIV_STAGES:0]   rdy;
    logic [satb_pkg::DIV_STAGES-1:0] stage_valid;
    satb_pkg::satb_px_t              stage_in  [satb_pkg::DIV_STAGES];
    satb_pkg::satb_px_t              px_next   [satb_pkg::DIV_STAGES];
    satb_pkg::satb_px_t              px_reg    [satb_pkg::DIV_STAGES];

    assign rdy[satb_pkg::DIV_STAGES] = out_ready;
    assign in_ready = rdy[0];
    assign out_valid = valid_reg[satb_pkg::DIV_STAGES-1];
    assign out_px = px_reg[satb_pkg::DIV_STAGES-1];

    for (genvar k = 0; k < satb_pkg::DIV_STAGES; k++) begin : g_stage
        localparam logic [2:0] SH_HI =
            3'(satb_pkg::DIV_BITS - 1 - satb_pkg::DIV_BITS_PER_STAGE * k);
        localparam logic [2:0] SH_LO = 3'(SH_HI - 3'd1);

        if (k == 0) begin : g_first
            assign stage_in[k] = in_px;
            assign stage_valid[k] = in_valid;
        end else begin : g_rest
            assign stage_in[k] = px_reg[k-1];
            assign stage_valid[k] = valid_reg[k-1];
        end

        assign rdy[k] = !valid_reg[k] || rdy[k+1];

        always_comb begin
            for (int i = 0; i < satb_pkg::NUM_CH; i++) begin
                px_next[k][i] = satb_pkg::div_step(
                    satb_pkg::div_step(stage_in[k][i], SH_HI), SH_LO);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                valid_reg[k] <= stage_valid[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && stage_valid[k]) begin
                px_reg[k] <= px_next[k];
            end
        end
    end

endmodule

>>> sv/satb_back.sv
// Back pipeline: gain scaling of the quotient, then add it to or subtract it from the channel and clamp.
module satb_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [satb_pkg::GAIN_W-1:0]   gain,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  satb_pkg::satb_px_t            in_px,
    output logic                          out_valid,
    input  logic                          out_ready,
    output satb_pkg::satb_rgb_t           out_rgb
);

    logic                         valid_a_reg, valid_b_reg;
    logic                         rdy_a, rdy_b;
    satb_pkg::satb_rgb_t          chan_a_reg;
    logic [satb_pkg::NUM_CH-1:0]  neg_a_reg;
    logic [satb_pkg::GAIN_W-1:0]  mag_a_reg  [satb_pkg::NUM_CH];
    logic [satb_pkg::GAIN_W-1:0]  mag_a_next [satb_pkg::NUM_CH];
    satb_pkg::satb_rgb_t          rgb_b_reg, rgb_b_next;

    assign rdy_b = !valid_b_reg || out_ready;
    assign rdy_a = !valid_a_reg || rdy_b;
    assign in_ready = rdy_a;
    assign out_valid = valid_b_reg;
    assign out_rgb = rgb_b_reg;

    always_comb begin
        logic [satb_pkg::PROD_W-1:0] prod;
        for (int i = 0; i < satb_pkg::NUM_CH; i++) begin
            prod = {{(satb_pkg::PROD_W - satb_pkg::CH_W){1'b0}}, in_px[i].q}
                 * {{(satb_pkg::PROD_W - satb_pkg::GAIN_W){1'b0}}, gain};
            mag_a_next[i] = prod[satb_pkg::GAIN_SHIFT +: satb_pkg::GAIN_W];
        end
    end

    always_comb begin
        logic [satb_pkg::GAIN_W:0] sum;
        for (int i = 0; i < satb_pkg::NUM_CH; i++) begin
            sum = {{(satb_pkg::GAIN_W + 1 - satb_pkg::CH_W){1'b0}}, chan_a_reg[i]}
                + {1'b0, mag_a_reg[i]};
            if (neg_a_reg[i]) begin
                if (mag_a_reg[i] > {{(satb_pkg::GAIN_W - satb_pkg::CH_W){1'b0}},
                                    chan_a_reg[i]}) begin
                    rgb_b_next[i] = '0;
                end else begin
                    rgb_b_next[i] = chan_a_reg[i] - mag_a_reg[i][satb_pkg::CH_W-1:0];
                end
            end else if (sum > {{(satb_pkg::GAIN_W + 1 - satb_pkg::CH_W){1'b0}},
                                satb_pkg::CHAN_MAX}) begin
                rgb_b_next[i] = satb_pkg::CHAN_MAX;
            end else begin
                rgb_b_next[i] = sum[satb_pkg::CH_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            if (rdy_a) begin
                valid_a_reg <= in_valid;
            end
            if (rdy_b) begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a && in_valid) begin
            for (int i = 0; i < satb_pkg::NUM_CH; i++) begin
                chan_a_reg[i] <= in_px[i].c;
                neg_a_reg[i] <= in_px[i].neg;
                mag_a_reg[i] <= mag_a_next[i];
            end
        end
        if (rdy_b && valid_a_reg) begin
            rgb_b_reg <= rgb_b_next;
        end
    end

endmodule

>>> tb/tb_rgb_color_saturation_enhance.sv
// Self-checking testbench for the RGB saturation enhancer with a built-in pixel predictor.
`timescale 1ns / 1ps

module tb_rgb_color_saturation_enhance;

    typedef struct packed {
        satb_pkg::satb_chan_t red;
        satb_pkg::satb_chan_t green;
        satb_pkg::satb_chan_t blue;
    } rgb_pixel_t;

    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 30;
    localparam int IDLE_PERCENT = 29;
    localparam int PHASE_ITEMS = 250;
    localparam int MAX_REPORTS = 10;
    localparam int FULL_SCALE = 255;
    localparam int DEN_OFFSET = 256;
    localparam int GAIN_MAX = (1 << satb_pkg::GAIN_W) - 1;
    localparam int GAIN_UNITY = 256;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [satb_pkg::GAIN_W-1:0]    cfg_wr_data;
    logic                           s_valid;
    logic                           s_ready;
    satb_pkg::satb_chan_t           s_red_in;
    satb_pkg::satb_chan_t           s_green_in;
    satb_pkg::satb_chan_t           s_blue_in;
    logic                           m_valid;
    logic                           m_ready;
    satb_pkg::satb_chan_t           m_red_out;
    satb_pkg::satb_chan_t           m_green_out;
    satb_pkg::satb_chan_t           m_blue_out;

    rgb_pixel_t         expected_pixels[$];
    int                 gain_model;
    int                 error_count;
    int                 cycle_count;
    bit                 no_idle;

    rgb_color_saturation_enhance u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    function automatic satb_pkg::satb_chan_t enhance_channel(input int c, input int m,
                                                             input int gain);
        int q;
        int mag;
        int v;
        if (c > m) begin
            q = ((c - m) * (FULL_SCALE - c)) / (DEN_OFFSET - m);
        end else begin
            q = ((c - m) * (FULL_SCALE - m)) / (DEN_OFFSET - c);
        end
        mag = (q < 0) ? -q : q;
        mag = (mag * gain) >> satb_pkg::GAIN_SHIFT;
        v = (q < 0) ? c - mag : c + mag;
        if (v < 0) begin
            v = 0;
        end
        if (v > FULL_SCALE) begin
            v = FULL_SCALE;
        end
        return satb_pkg::satb_chan_t'(v);
    endfunction

    function automatic rgb_pixel_t predict_pixel(input satb_pkg::satb_chan_t r,
                                                 input satb_pkg::satb_chan_t g,
                                                 input satb_pkg::satb_chan_t b,
                                                 input int gain);
        rgb_pixel_t px;
        int mean;
        mean = (int'(r) + int'(g) + int'(b)) / 3;
        px.red = enhance_channel(int'(r), mean, gain);
        px.green = enhance_channel(int'(g), mean, gain);
        px.blue = enhance_channel(int'(b), mean, gain);
        return px;
    endfunction

    always @(posedge aclk) begin
        rgb_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("unexpected output transaction: r=%0d g=%0d b=%0d",
                             m_red_out, m_green_out, m_blue_out);
                end
            end else begin
                want = expected_pixels.pop_front();
                if (m_red_out !== want.red || m_green_out !== want.green ||
                    m_blue_out !== want.blue) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 want.red, want.green, want.blue,
                                 m_red_out, m_green_out, m_blue_out);
                    end
                end
            end
        end
    end

    task automatic send_pixel(input satb_pkg::satb_chan_t r, input satb_pkg::satb_chan_t g,
                              input satb_pkg::satb_chan_t b);
        @(negedge aclk);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                s_valid = 1'b0;
                s_red_in = satb_pkg::satb_chan_t'($urandom);
                s_green_in = satb_pkg::satb_chan_t'($urandom);
                s_blue_in = satb_pkg::satb_chan_t'($urandom);
                @(negedge aclk);
            end
        end
        s_valid = 1'b1;
        s_red_in = r;
        s_green_in = g;
        s_blue_in = b;
        do @(posedge aclk); while (!s_ready);
        expected_pixels.push_back(predict_pixel(r, g, b, gain_model));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_pixels.size() != 0) @(negedge aclk);
    endtask

    task automatic set_gain(input int value);
        wait_drained();
        cfg_wr_en = 1'b1;
        cfg_wr_data = value[satb_pkg::GAIN_W-1:0];
        gain_model = value & GAIN_MAX;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic test_reset_gain();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd200, 8'd100, 8'd50);
    endtask

    task automatic test_zero_gain();
        set_gain(0);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd10, 8'd240, 8'd130);
        send_pixel(8'd170, 8'd85, 8'd170);
        send_pixel(8'd254, 8'd1, 8'd127);
    endtask

    task automatic test_max_gain();
        set_gain(GAIN_MAX);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd1, 8'd2);
        send_pixel(8'd200, 8'd100, 8'd50);
        send_pixel(8'd90, 8'd90, 8'd91);
        send_pixel(8'd0, 8'd128, 8'd255);
    endtask

    task automatic test_random_pixels(input int gain, input int count, input bit quiet);
        int kind;
        int base;
        int pick;
        int lead;
        int ch[3];
        set_gain(gain);
        no_idle = quiet;
        repeat (count) begin
            kind = $urandom_range(0, 9);
            base = $urandom_range(0, 255);
            lead = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) begin
                if (kind <= 5) begin
                    ch[i] = $urandom_range(0, 255);
                end else if (kind <= 7) begin
                    ch[i] = base + $urandom_range(0, 8) - 4;
                    if (ch[i] < 0) begin
                        ch[i] = 0;
                    end
                    if (ch[i] > FULL_SCALE) begin
                        ch[i] = FULL_SCALE;
                    end
                end else if (kind == 8) begin
                    pick = $urandom_range(0, 3);
                    ch[i] = (pick < 2) ? pick : 252 + pick;
                end else begin
                    ch[i] = (i == lead) ? $urandom_range(200, 255) : $urandom_range(0, 60);
                end
            end
            send_pixel(satb_pkg::satb_chan_t'(ch[0]), satb_pkg::satb_chan_t'(ch[1]),
                       satb_pkg::satb_chan_t'(ch[2]));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_red_in = '0;
        s_green_in = '0;
        s_blue_in = '0;
        m_ready = 1'b0;
        no_idle = 1'b0;
        gain_model = GAIN_UNITY;
        error_count = 0;
        cycle_count = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_gain();
        test_zero_gain();
        test_max_gain();
        test_random_pixels(GAIN_UNITY, PHASE_ITEMS, 1'b0);
        test_random_pixels(GAIN_MAX, PHASE_ITEMS, 1'b0);
        test_random_pixels(0, PHASE_ITEMS, 1'b0);
        test_random_pixels(1, PHASE_ITEMS, 1'b0);
        test_random_pixels($urandom_range(0, GAIN_MAX), PHASE_ITEMS, 1'b1);
        test_random_pixels(2048, PHASE_ITEMS, 1'b0);
        test_random_pixels($urandom_range(0, GAIN_MAX), PHASE_ITEMS, 1'b0);
        test_random_pixels($urandom_range(0, 511), PHASE_ITEMS, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
